/* sv/cpfb_pkg.sv */
// Shared types and constants of the complex polyphase FIR filter bank.
package cpfb_pkg;

    // Field widths of the payload and of the configuration registers.
    localparam int SAMPLE_BITS = 16;
    localparam int FI_W        = 5;
    localparam int TI_W        = 6;
    localparam int FILT_REG_W  = 6;
    localparam int TAPS_REG_W  = 7;
    localparam int SCALE_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Fixed-point format: Q1.15 data, Q4.12 scale.
    localparam int FRAC_BITS  = SAMPLE_BITS - 1;
    localparam int SCALE_FRAC = 12;
    localparam int OUT_SHIFT  = FRAC_BITS + SCALE_FRAC;
    localparam int SPLIT_BITS = 16;

    // Default storage sizes.
    localparam int DEF_MAX_FILTERS = 32;
    localparam int DEF_MAX_TAPS    = 64;

    // Register reset values.
    localparam logic [FILT_REG_W-1:0]  RST_FILTERS = FILT_REG_W'(32);
    localparam logic [TAPS_REG_W-1:0]  RST_TAPS    = TAPS_REG_W'(64);
    localparam logic signed [SCALE_W-1:0] RST_SCALE = SCALE_W'(4096);

    typedef enum logic [1:0] {
        OP_LOAD         = 2'd0,
        OP_PUSH         = 2'd1,
        OP_COMPUTE      = 2'd2,
        OP_PUSH_COMPUTE = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTERS = 2'd0,
        CFG_TAPS    = 2'd1,
        CFG_SCALE   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCL_RE,
        ST_FIN_RE,
        ST_SCL_IM,
        ST_FIN_IM,
        ST_PUT
    } t_state;

    typedef struct packed {
        t_opcode                        opcode;
        logic [FI_W-1:0]                filter_index;
        logic [TI_W-1:0]                tap_index;
        logic signed [SAMPLE_BITS-1:0]  data_re;
        logic signed [SAMPLE_BITS-1:0]  data_im;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  out_re;
        logic signed [SAMPLE_BITS-1:0]  out_im;
        logic                           index_error;
    } t_out_item;

endpackage

/* sv/cpfb_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module cpfb_ram #(
    parameter int WIDTH = 2 * cpfb_pkg::SAMPLE_BITS,
    parameter int DEPTH = cpfb_pkg::DEF_MAX_TAPS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/complex_polyphase_fir_filterbank_core.sv */
// Top level of the complex polyphase FIR filter bank: sequencer, shared complex MAC, scaler.
//
//  channel   direction  handshake                  beat contents
//  in        input      i_in_valid / o_in_stall    t_in_item (opcode, indexes, sample)
//  out       output     o_out_valid / i_out_stall  t_out_item (out_re, out_im, index_error)
//  cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A load or push beat leaves the input free for the next beat. A compute beat runs one
// complex multiply-accumulate per tap through a single shared MAC fed by the coefficient
// and window RAMs (none when no taps are in use), drains the MAC pipeline, scales and
// saturates the real and then the imaginary sum, and loads the result into the output
// register; a bad filter index skips the MAC and scaler and returns a zero result.
// The input stays stalled while a compute is in flight or its result is held back.
// Reset is synchronous; the sample window reads as zero for taps not yet pushed.
module complex_polyphase_fir_filterbank_core #(
    parameter int MAX_FILTERS = cpfb_pkg::DEF_MAX_FILTERS,
    parameter int MAX_TAPS    = cpfb_pkg::DEF_MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  cpfb_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output cpfb_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [cpfb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cpfb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int SB     = cpfb_pkg::SAMPLE_BITS;
    localparam int AW     = $clog2(MAX_FILTERS * MAX_TAPS);
    localparam int PW     = $clog2(MAX_TAPS);
    localparam int TW     = $clog2(MAX_TAPS + 1);
    localparam int FC_W   = ($clog2(MAX_FILTERS + 1) > cpfb_pkg::FILT_REG_W) ?
                            $clog2(MAX_FILTERS + 1) : cpfb_pkg::FILT_REG_W;
    localparam int TC_W   = ($clog2(MAX_TAPS + 1) > cpfb_pkg::TAPS_REG_W) ?
                            $clog2(MAX_TAPS + 1) : cpfb_pkg::TAPS_REG_W;
    localparam int PROD_W = 2 * SB;
    localparam int ACC_W  = PROD_W + 1 + $clog2(MAX_TAPS);
    localparam int SPL    = cpfb_pkg::SPLIT_BITS;
    localparam int HI_W   = ACC_W - SPL;
    localparam int SW     = cpfb_pkg::SCALE_W;
    localparam int LOP_W  = SPL + 1 + SW;
    localparam int Q_W    = LOP_W + 1;
    localparam int P_W    = ACC_W + 1;
    localparam int RSH    = cpfb_pkg::OUT_SHIFT - SPL;
    localparam int R_W    = P_W - RSH;
    localparam logic signed [Q_W-1:0] Q_HALF = Q_W'(1) <<< (cpfb_pkg::OUT_SHIFT - 1);
    localparam logic signed [R_W-1:0] R_MAX  = R_W'((1 << cpfb_pkg::FRAC_BITS) - 1);
    localparam logic signed [R_W-1:0] R_MIN  = -(R_W'(1) <<< cpfb_pkg::FRAC_BITS);

    // Control and configuration.
    cpfb_pkg::t_state r_state, n_state;
    logic [cpfb_pkg::FILT_REG_W-1:0] r_filters;
    logic [cpfb_pkg::TAPS_REG_W-1:0] r_taps;
    logic signed [SW-1:0]            r_scale;
    logic [PW-1:0]                   r_head;
    logic [TW-1:0]                   r_fill;
    logic [AW-1:0]                   r_base;
    logic [PW-1:0]                   r_pos;
    logic [TW-1:0]                   r_n;
    logic [TW-1:0]                   r_tend;
    logic                            r_v1, r_v2, r_w1;
    logic                            r_ovalid;

    // Datapath.
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [ACC_W-1:0]  r_acc_re, r_acc_im;
    logic signed [Q_W-1:0]    r_q;
    logic signed [ACC_W-1:0]  r_hs;
    logic signed [SB-1:0]     r_res_re, r_res_im;
    logic                     r_err;
    cpfb_pkg::t_out_item      r_out;

    logic                     in_acc, do_load, do_push, do_comp, idx_bad;
    logic                     issue, last_issue, load_out, out_take;
    logic [FC_W-1:0]          m_eff;
    logic [TW-1:0]            t_eff;
    logic [PW-1:0]            head_dec, new_head;
    logic [AW-1:0]            load_addr, coef_raddr;
    logic [2*SB-1:0]          coef_rdata, win_rdata;
    logic signed [SB-1:0]     c_re, c_im, x_re, x_im;
    logic signed [ACC_W-1:0]  acc_sel;
    logic signed [HI_W-1:0]   acc_hi;
    logic signed [SPL:0]      acc_lo;
    logic signed [LOP_W-1:0]  prod_lo;
    logic signed [ACC_W-1:0]  prod_hi;
    logic signed [P_W-1:0]    p_sum;
    logic signed [R_W-1:0]    r_shift;
    logic signed [SB-1:0]     sat_val;

    // ---------------------------------------------------------------- decode
    assign in_acc   = i_in_valid && !o_in_stall;
    assign idx_bad  = FC_W'(i_in.filter_index) >= m_eff;
    assign do_load  = in_acc && (i_in.opcode == cpfb_pkg::OP_LOAD) &&
                      (FC_W'(i_in.filter_index) < FC_W'(MAX_FILTERS)) &&
                      (TC_W'(i_in.tap_index) < TC_W'(MAX_TAPS));
    assign do_push  = in_acc && ((i_in.opcode == cpfb_pkg::OP_PUSH) ||
                                 (i_in.opcode == cpfb_pkg::OP_PUSH_COMPUTE));
    assign do_comp  = in_acc && ((i_in.opcode == cpfb_pkg::OP_COMPUTE) ||
                                 (i_in.opcode == cpfb_pkg::OP_PUSH_COMPUTE));

    assign m_eff = (FC_W'(r_filters) > FC_W'(MAX_FILTERS)) ? FC_W'(MAX_FILTERS) :
                   FC_W'(r_filters);
    assign t_eff = (TC_W'(r_taps) > TC_W'(MAX_TAPS)) ? TW'(MAX_TAPS) : TW'(r_taps);

    assign head_dec  = (r_head == '0) ? PW'(MAX_TAPS - 1) : r_head - 1'b1;
    assign new_head  = do_push ? head_dec : r_head;
    assign load_addr = AW'(AW'(i_in.filter_index) * AW'(MAX_TAPS)) + AW'(i_in.tap_index);
    assign coef_raddr = r_base + AW'(r_n);

    assign issue      = (r_state == cpfb_pkg::ST_MAC);
    assign last_issue = (r_n == r_tend - 1'b1);
    assign out_take   = r_ovalid && !i_out_stall;

    // ---------------------------------------------------------------- memories
    cpfb_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_FILTERS * MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (load_addr),
        .i_wdata ({i_in.data_re, i_in.data_im}),
        .i_raddr (coef_raddr),
        .o_rdata (coef_rdata)
    );

    cpfb_ram #(
        .WIDTH (2 * SB),
        .DEPTH (MAX_TAPS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (head_dec),
        .i_wdata ({i_in.data_re, i_in.data_im}),
        .i_raddr (r_pos),
        .o_rdata (win_rdata)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpfb_pkg::ST_IDLE: begin
                if (do_comp) begin
                    priority if (idx_bad) begin
                        n_state = cpfb_pkg::ST_PUT;
                    end else if (t_eff == '0) begin
                        n_state = cpfb_pkg::ST_DRAIN;
                    end else begin
                        n_state = cpfb_pkg::ST_MAC;
                    end
                end
            end
            cpfb_pkg::ST_MAC: begin
                if (last_issue) begin
                    n_state = cpfb_pkg::ST_DRAIN;
                end
            end
            cpfb_pkg::ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = cpfb_pkg::ST_SCL_RE;
                end
            end
            cpfb_pkg::ST_SCL_RE: n_state = cpfb_pkg::ST_FIN_RE;
            cpfb_pkg::ST_FIN_RE: n_state = cpfb_pkg::ST_SCL_IM;
            cpfb_pkg::ST_SCL_IM: n_state = cpfb_pkg::ST_FIN_IM;
            cpfb_pkg::ST_FIN_IM: n_state = cpfb_pkg::ST_PUT;
            cpfb_pkg::ST_PUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_state = cpfb_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != cpfb_pkg::ST_IDLE);
        load_out   = (r_state == cpfb_pkg::ST_PUT) && (!r_ovalid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cpfb_pkg::ST_IDLE;
            r_filters <= cpfb_pkg::RST_FILTERS;
            r_taps    <= cpfb_pkg::RST_TAPS;
            r_scale   <= cpfb_pkg::RST_SCALE;
            r_head    <= '0;
            r_fill    <= '0;
            r_n       <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    cpfb_pkg::CFG_FILTERS: r_filters <= i_cfg_data[cpfb_pkg::FILT_REG_W-1:0];
                    cpfb_pkg::CFG_TAPS:    r_taps    <= i_cfg_data[cpfb_pkg::TAPS_REG_W-1:0];
                    cpfb_pkg::CFG_SCALE:   r_scale   <= $signed(i_cfg_data[SW-1:0]);
                    default: ;
                endcase
            end
            r_head <= new_head;
            if (do_push && (r_fill != TW'(MAX_TAPS))) begin
                r_fill <= r_fill + 1'b1;
            end
            if (do_comp) begin
                r_n <= '0;
            end else if (issue) begin
                r_n <= r_n + 1'b1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (out_take) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- MAC datapath
    assign c_re = $signed(coef_rdata[2*SB-1:SB]);
    assign c_im = $signed(coef_rdata[SB-1:0]);
    // Taps beyond the samples pushed since reset read as zero.
    assign x_re = r_w1 ? $signed(win_rdata[2*SB-1:SB]) : '0;
    assign x_im = r_w1 ? $signed(win_rdata[SB-1:0]) : '0;

    always_ff @(posedge i_clk) begin
        if (do_comp) begin
            r_pos  <= new_head;
            r_base <= AW'(AW'(i_in.filter_index) * AW'(MAX_TAPS));
            r_tend <= t_eff;
        end else if (issue) begin
            r_pos <= (r_pos == PW'(MAX_TAPS - 1)) ? '0 : r_pos + 1'b1;
        end
        r_w1   <= (r_n < r_fill);
        r_p_rr <= c_re * x_re;
        r_p_ii <= c_im * x_im;
        r_p_ri <= c_re * x_im;
        r_p_ir <= c_im * x_re;
        if (do_comp) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v2) begin
            r_acc_re <= r_acc_re + ACC_W'(r_p_rr) - ACC_W'(r_p_ii);
            r_acc_im <= r_acc_im + ACC_W'(r_p_ri) + ACC_W'(r_p_ir);
        end
    end

    // ---------------------------------------------------------------- scaler
    // The accumulator is split into a signed high part and an unsigned low
    // part of SPLIT_BITS bits so each multiply by the scale stays narrow; the
    // rounding constant rides on the low product.
    assign acc_sel = (r_state == cpfb_pkg::ST_SCL_IM) ? r_acc_im : r_acc_re;
    assign acc_hi  = HI_W'(acc_sel >>> SPL);
    assign acc_lo  = $signed({1'b0, acc_sel[SPL-1:0]});
    assign prod_lo = acc_lo * r_scale;
    assign prod_hi = acc_hi * r_scale;

    assign p_sum   = P_W'(r_hs) + P_W'(r_q >>> SPL);
    assign r_shift = R_W'(p_sum >>> RSH);

    always_comb begin
        priority if (r_shift > R_MAX) begin
            sat_val = SB'(R_MAX);
        end else if (r_shift < R_MIN) begin
            sat_val = SB'(R_MIN);
        end else begin
            sat_val = SB'(r_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q  <= Q_W'(prod_lo) + Q_HALF;
        r_hs <= prod_hi;
        if (do_comp) begin
            r_err <= idx_bad;
            if (idx_bad) begin
                r_res_re <= '0;
                r_res_im <= '0;
            end
        end
        if (r_state == cpfb_pkg::ST_FIN_RE) begin
            r_res_re <= sat_val;
        end
        if (r_state == cpfb_pkg::ST_FIN_IM) begin
            r_res_im <= sat_val;
        end
        if (load_out) begin
            r_out.out_re      <= r_res_re;
            r_out.out_im      <= r_res_im;
            r_out.index_error <= r_err;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule

/* sv/cpfb_checker.sv */
// Port-level checker for the filter bank core and its bind to the top level.
module cpfb_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input cpfb_pkg::t_in_item              i_in,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input cpfb_pkg::t_out_item             o_out
);

    logic in_beat;
    logic comp_op;
    logic quiet_op;

    assign in_beat  = i_in_valid && !o_in_stall;
    assign comp_op  = (i_in.opcode == cpfb_pkg::OP_COMPUTE) ||
                      (i_in.opcode == cpfb_pkg::OP_PUSH_COMPUTE);
    assign quiet_op = (i_in.opcode == cpfb_pkg::OP_LOAD) ||
                      (i_in.opcode == cpfb_pkg::OP_PUSH);

    // A result that is held back stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("output beat changed while stalled");

    // A compute beat occupies the block on the next cycle.
    a_comp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && comp_op |=> o_in_stall)
        else $error("input not stalled after a compute beat");

    // Loads and pushes produce no result.
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && quiet_op && !o_out_valid |=> !o_out_valid)
        else $error("result appeared after a load or push beat");

    // A flagged index carries a zero sample.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.index_error |-> (o_out.out_re == '0) && (o_out.out_im == '0))
        else $error("index error with nonzero output");

    // A new result only appears while the input side was busy.
    a_rise_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a compute in flight");

endmodule

bind complex_polyphase_fir_filterbank_core cpfb_checker u_cpfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
